// File: rtl/core/lie_pkg.sv
// Shared types and constants of the line input editor.
`timescale 1ns / 1ps

package lie_pkg;

    localparam int LEN_W     = 7;   // line length field, holds 0..64
    localparam int CHAR_W    = 8;
    localparam int CMDQ_DEPTH = 4;  // command queue between front and back
    localparam int CMDQ_AW    = 2;

    localparam logic [CHAR_W-1:0] CH_CR     = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BS     = 8'd8;
    localparam logic [CHAR_W-1:0] CH_CTRL_C = 8'd3;
    localparam logic [CHAR_W-1:0] CH_CTRL_D = 8'd4;
    localparam logic [CHAR_W-1:0] CH_CTRL_Z = 8'd26;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_BACK,
        OP_CLEAR,
        OP_END
    } lie_op_t;

    typedef struct packed {
        lie_op_t            op;
        logic [CHAR_W-1:0]  data;
    } lie_cmd_t;

    // front -> back command channel
    typedef struct packed {
        logic     valid;
        lie_cmd_t cmd;
    } lie_cmdq_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } lie_state_t;

endpackage

// File: rtl/core/line_input_editor.sv
// Top level of the line input editor.
`timescale 1ns / 1ps
//
// Assembles a command line from received bytes (rx_byte, in_valid/in_ready)
// and emits the finished line one character per item on the output channel
// (line_char, is_last, line_empty, line_length, out_valid/out_ready).
// Backspace drops the last stored character, ctrl-C/D/Z discard the line,
// CR or LF ends it. An empty line gives one item with line_empty set.
//
// The front classifies each byte and writes a command into a 4-entry queue;
// the back applies commands to the line store and fill count one per cycle.
// Ordinary bytes therefore flow at one item per cycle. A line end holds the
// back in its emit state (one store read per character, one item for an empty
// line); the queue keeps taking bytes meanwhile until it fills.
// A line end passes the queue, emit state, read stage and output register.
//
// Reset empties the queue, clears the fill count and drops any line being
// emitted. A stalled receiver holds the output register; the read stage
// behind it holds too, and the back stops reading the store until it moves.

module line_input_editor
    import lie_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] rx_byte,
    input  logic              in_valid,
    output logic              in_ready,
    output logic [CHAR_W-1:0] line_char,
    output logic              is_last,
    output logic              line_empty,
    output logic [LEN_W-1:0]  line_length,
    output logic              out_valid,
    input  logic              out_ready
);

    lie_cmdq_t cmdq;
    logic      cmd_pop;

    lie_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmdq     (cmdq),
        .cmd_pop  (cmd_pop)
    );

    lie_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmdq        (cmdq),
        .cmd_pop     (cmd_pop),
        .line_char   (line_char),
        .is_last     (is_last),
        .line_empty  (line_empty),
        .line_length (line_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

// File: rtl/core/lie_front.sv
// Front end: classifies received bytes and queues editing commands.
`timescale 1ns / 1ps

module lie_front
    import lie_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] rx_byte,
    input  logic              in_valid,
    output logic              in_ready,
    output lie_cmdq_t         cmdq,
    input  logic              cmd_pop
);

    lie_cmd_t              q_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_AW:0]      cnt_reg, cnt_next;
    lie_cmd_t              cls;
    logic                  push;
    logic                  pop;

    always_comb
    begin
        cls.data = rx_byte;
        unique case (rx_byte) inside
            CH_CR, CH_LF:                   cls.op = OP_END;
            CH_BS:                          cls.op = OP_BACK;
            CH_CTRL_C, CH_CTRL_D, CH_CTRL_Z: cls.op = OP_CLEAR;
            default:                        cls.op = OP_APPEND;
        endcase
    end

    assign in_ready   = (cnt_reg != (CMDQ_AW+1)'(CMDQ_DEPTH));
    assign push       = in_valid && in_ready;
    assign cmdq.valid = (cnt_reg != '0);
    assign cmdq.cmd   = q_reg[rd_ptr_reg];
    assign pop        = cmd_pop && cmdq.valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (CMDQ_AW+1)'(push) - (CMDQ_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// File: rtl/core/lie_back.sv
// Back end: line store, fill count and emission of completed lines.
`timescale 1ns / 1ps

module lie_back
    import lie_pkg::*;
#(
    parameter int LINE_CAPACITY = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lie_cmdq_t         cmdq,
    output logic              cmd_pop,
    output logic [CHAR_W-1:0] line_char,
    output logic              is_last,
    output logic              line_empty,
    output logic [LEN_W-1:0]  line_length,
    output logic              out_valid,
    input  logic              out_ready
);

    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

    logic [CHAR_W-1:0]  mem [LINE_CAPACITY];
    logic [CHAR_W-1:0]  rd_data_reg;

    lie_state_t         state_reg, state_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [AW-1:0]      idx_reg, idx_next;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_last_reg, s1_empty_reg;
    logic [LEN_W-1:0]   s1_len_reg;

    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  line_char_reg;
    logic               is_last_reg, line_empty_reg;
    logic [LEN_W-1:0]   line_length_reg;

    logic               s1_move;
    logic               issue;
    logic               issue_last;
    logic               wr_en;
    logic               rd_en;

    assign s1_move    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign issue      = (state_reg == ST_EMIT) && (!s1_valid_reg || s1_move);
    assign issue_last = (len_reg == '0) || (LEN_W'(idx_reg) == len_reg - 1'b1);
    assign rd_en      = issue && (len_reg != '0);
    assign cmd_pop    = (state_reg == ST_IDLE) && cmdq.valid;
    assign wr_en      = cmd_pop && (cmdq.cmd.op == OP_APPEND) && (count_reg < CAP);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop)
                begin
                    unique case (cmdq.cmd.op)
                        OP_APPEND:
                        begin
                            if (count_reg < CAP)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_BACK:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_END:
                        begin
                            len_next   = count_reg;
                            idx_next   = '0;
                            count_next = '0;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (issue_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next  = issue || (s1_valid_reg && !s1_move);
        out_valid_next = s1_move || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // line store, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= cmdq.cmd.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_last_reg  <= issue_last;
            s1_empty_reg <= (len_reg == '0);
            s1_len_reg   <= len_reg;
        end
        if (s1_move)
        begin
            line_char_reg   <= s1_empty_reg ? '0 : rd_data_reg;
            is_last_reg     <= s1_last_reg;
            line_empty_reg  <= s1_empty_reg;
            line_length_reg <= s1_len_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_char   = line_char_reg;
    assign is_last     = is_last_reg;
    assign line_empty  = line_empty_reg;
    assign line_length = line_length_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("fill count above capacity");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_empty |-> is_last && (line_length == '0))
        else $error("empty line item not marked last");

    a_no_pop_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !cmd_pop && !wr_en)
        else $error("command taken during emission");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && (cmdq.cmd.op == OP_END) |=> (count_reg == '0) && (state_reg == ST_EMIT))
        else $error("line end did not clear the fill count");

endmodule

// File: test/tb_top.sv
// Testbench for the line input editor: directed and random byte streams checked against a line predictor.
`timescale 1ns / 1ps

module tb_top;
    import lie_pkg::*;

    localparam int LINE_CAP   = 64;
    localparam int CYCLE_CAP  = 3000000; // well above every byte emitting a full line under max stalls
    localparam int TAIL_ITEMS = 40;      // last stretch of the run goes without idling

    // one expected output item
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              empty;
        logic [LEN_W-1:0]  len;
    } line_res_t;

    // one byte waiting to be sent; drain holds it back until all results are in
    typedef struct packed {
        logic [CHAR_W-1:0] data;
        logic              drain;
    } rx_item_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic [CHAR_W-1:0] rx_byte   = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [CHAR_W-1:0] line_char;
    logic              is_last;
    logic              line_empty;
    logic [LEN_W-1:0]  line_length;
    logic              out_valid;
    logic              out_ready = 1'b0;

    rx_item_t  tx_items[$];       // bytes still to be offered
    line_res_t line_results[$];   // results predicted but not yet seen

    // predictor state
    logic [CHAR_W-1:0] line_buf[LINE_CAP];
    int                line_fill = 0;

    int   fails      = 0;
    int   cycles     = 0;
    int   gap_left   = 0;
    int   hold_left  = 0;
    bit   drain_wait = 0;
    bit   held_long  = 0;
    logic res_idle   = 1'b1;      // registered copy of "nothing expected"
    logic tail_phase = 1'b0;      // set once the driver is in the idle-free tail

    line_input_editor #(
        .LINE_CAPACITY(LINE_CAP)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .line_char  (line_char),
        .is_last    (is_last),
        .line_empty (line_empty),
        .line_length(line_length),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Line predictor: applies one accepted byte and queues what a line end emits.
    task automatic editor_take(input logic [CHAR_W-1:0] b);
        line_res_t r;
        case (b)
            CH_CR, CH_LF:
            begin
                if (line_fill == 0)
                begin
                    // empty line end: one marker item, char 0
                    r.ch    = '0;
                    r.last  = 1'b1;
                    r.empty = 1'b1;
                    r.len   = '0;
                    line_results.push_back(r);
                end
                else
                begin
                    for (int k = 0; k < line_fill; k++)
                    begin
                        r.ch    = line_buf[k];
                        r.last  = (k == line_fill - 1);
                        r.empty = 1'b0;
                        r.len   = LEN_W'(line_fill);
                        line_results.push_back(r);
                    end
                end
                line_fill = 0;
            end
            CH_BS:
            begin
                // backspace on an empty line does nothing
                if (line_fill > 0)
                    line_fill--;
            end
            CH_CTRL_C, CH_CTRL_D, CH_CTRL_Z:
                line_fill = 0;
            default:
            begin
                // zero byte is an ordinary char; a full line drops the byte
                if (line_fill < LINE_CAP)
                begin
                    line_buf[line_fill] = b;
                    line_fill++;
                end
            end
        endcase
    endtask

    function automatic bit is_ctrl(input logic [CHAR_W-1:0] b);
        return b == CH_CR || b == CH_LF || b == CH_BS ||
               b == CH_CTRL_C || b == CH_CTRL_D || b == CH_CTRL_Z;
    endfunction

    // random byte that the editor stores as a character
    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] b;
        b = CHAR_W'($urandom);
        while (is_ctrl(b))
            b = CHAR_W'($urandom);
        return b;
    endfunction

    task automatic push_byte(input logic [CHAR_W-1:0] b, input bit drain = 0);
        rx_item_t it;
        it.data  = b;
        it.drain = drain;
        tx_items.push_back(it);
    endtask

    // Driver: offers the next queued byte whenever the bus slot is free.
    // Valid stays up with a stable byte until the editor takes it.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (tx_items.size() == 0)
                in_valid <= 1'b0;
            else if (tx_items[0].drain && !drain_wait)
            begin
                // first idle cycle of a drain pause; res_idle is valid from the next edge
                drain_wait = 1;
                in_valid <= 1'b0;
            end
            else if (drain_wait && !res_idle)
                in_valid <= 1'b0;
            else
            begin
                drain_wait = 0;
                rx_byte  <= tx_items[0].data;
                in_valid <= 1'b1;
                void'(tx_items.pop_front());
                if (tx_items.size() < TAIL_ITEMS)
                    tail_phase <= 1'b1;
                else if ($urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 17);
            end
        end
    end

    // Monitor: predicts from accepted bytes, checks accepted results,
    // and paces out_ready (short random stalls plus one long hold-off).
    always @(posedge clk)
    begin
        line_res_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            res_idle  <= 1'b1;
        end
        else
        begin
            if (in_valid && in_ready)
                editor_take(rx_byte);

            if (out_valid && out_ready)
            begin
                if (line_results.size() == 0)
                begin
                    $error("unexpected item: line_char %0d is_last %0d line_empty %0d len %0d",
                           line_char, is_last, line_empty, line_length);
                    fails++;
                end
                else
                begin
                    want = line_results.pop_front();
                    if (line_char !== want.ch)
                    begin
                        $error("line_char: expected %0d, got %0d", want.ch, line_char);
                        fails++;
                    end
                    if (is_last !== want.last)
                    begin
                        $error("is_last: expected %0d, got %0d", want.last, is_last);
                        fails++;
                    end
                    if (line_empty !== want.empty)
                    begin
                        $error("line_empty: expected %0d, got %0d", want.empty, line_empty);
                        fails++;
                    end
                    if (line_length !== want.len)
                    begin
                        $error("line_length: expected %0d, got %0d", want.len, line_length);
                        fails++;
                    end
                end
            end

            res_idle <= (line_results.size() == 0);

            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!held_long && line_results.size() >= 10)
            begin
                // long hold-off mid-line: the command queue fills and in_ready drops
                held_long = 1;
                hold_left = 399;
                out_ready <= 1'b0;
            end
            else if (!tail_phase && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(0, 16);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int rand_items;
        int len;
        int pick;
        int n_bs;
        bit drain;

        // --- directed part ---
        push_byte(CH_CR);                          // empty line, CR
        push_byte(CH_LF);                          // empty line, LF
        push_byte(8'h41);                          // extremes incl. zero byte stored as char
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_CR);
        push_byte(CH_BS);                          // backspace on empty line
        push_byte(8'h78);
        push_byte(8'h79);
        push_byte(CH_BS);
        push_byte(CH_LF);
        push_byte(8'h71);                          // discard by ctrl-C, then empty end
        push_byte(CH_CTRL_C);
        push_byte(CH_CR);
        push_byte(8'h72);                          // ctrl-D and ctrl-Z discards
        push_byte(CH_CTRL_D);
        push_byte(8'h73);
        push_byte(CH_CTRL_Z);
        push_byte(CH_LF);
        push_byte(8'h7F, 1'b1);                    // sent only once the editor is drained
        push_byte(8'h80);
        push_byte(CH_CR);

        // --- random part: mostly well-formed lines, some broken lines and noise ---
        rand_items = 0;
        while (rand_items < 400)
        begin
            pick  = $urandom_range(0, 19);
            drain = ($urandom_range(0, 24) == 0);
            if (pick < 14)
            begin
                // well-formed line; a few overflow the store
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(60, 70);
                    1, 2, 3: len = $urandom_range(13, 40);
                    default: len = $urandom_range(0, 12);
                endcase
                for (int k = 0; k < len; k++)
                begin
                    push_byte(plain_char(), drain && k == 0);
                    if (k < LINE_CAP)
                        rand_items++;
                    if (len < LINE_CAP && $urandom_range(0, 9) == 0)
                    begin
                        push_byte(CH_BS);
                        rand_items++;
                    end
                end
                push_byte($urandom_range(0, 1) ? CH_CR : CH_LF, drain && len == 0);
                rand_items++;
            end
            else if (pick < 17)
            begin
                // broken line: discarded by a ctrl code, or over-erased
                len = $urandom_range(0, 8);
                for (int k = 0; k < len; k++)
                    push_byte(plain_char());
                if ($urandom_range(0, 1))
                begin
                    case ($urandom_range(0, 2))
                        0:       push_byte(CH_CTRL_C);
                        1:       push_byte(CH_CTRL_D);
                        default: push_byte(CH_CTRL_Z);
                    endcase
                    rand_items += len + 1;
                end
                else
                begin
                    n_bs = len + $urandom_range(1, 3);
                    for (int k = 0; k < n_bs; k++)
                        push_byte(CH_BS);
                    push_byte(CH_CR);
                    rand_items += 2 * len + 1;
                end
            end
            else
            begin
                // noise: any byte at all
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    push_byte(CHAR_W'($urandom));
                rand_items += len;
            end
        end
        push_byte(CH_CR);                          // flush whatever the noise left behind

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // sample at the falling edge, away from the driver's updates
        @(negedge clk);
        while (tx_items.size() != 0 || in_valid)
            @(negedge clk);
        while (line_results.size() != 0)
            @(negedge clk);
        // let any stray item show up past the last expected one
        repeat (20) @(negedge clk);

        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
